// ===== rtl/lcru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcru_pkg
// Shared sizes, operation and command codes, and the controller/datapath
// command and status structs of the LU column scale and rank-one update unit.
// ----------------------------------------------------------------------------
package lcru_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 64;

  // Wide enough for a register value and for either maximum count.
  localparam int DIM_W = (ROW_W > COL_W) ? ROW_W + 1 : COL_W + 1;
  localparam int CNT_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd2;

  // What one element does.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_PASS   = 3'd0;
  localparam logic [OP_W-1:0] OP_FACTOR = 3'd1;
  localparam logic [OP_W-1:0] OP_RECIP  = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALE  = 3'd3;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd4;

  // Datapath commands.
  localparam int CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_NOP     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE = 5'd1;
  localparam logic [CMD_W-1:0] CMD_FSEL    = 5'd2;
  localparam logic [CMD_W-1:0] CMD_FSPEC   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_MUL     = 5'd4;
  localparam logic [CMD_W-1:0] CMD_LOADP   = 5'd5;
  localparam logic [CMD_W-1:0] CMD_NORM    = 5'd6;
  localparam logic [CMD_W-1:0] CMD_LOADC   = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SAVEC   = 5'd8;
  localparam logic [CMD_W-1:0] CMD_ALIGN   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_ADD     = 5'd10;
  localparam logic [CMD_W-1:0] CMD_ROUND   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_RSPEC   = 5'd12;
  localparam logic [CMD_W-1:0] CMD_DIVINIT = 5'd13;
  localparam logic [CMD_W-1:0] CMD_DIV     = 5'd14;
  localparam logic [CMD_W-1:0] CMD_LOADQ   = 5'd15;
  localparam logic [CMD_W-1:0] CMD_FINISH  = 5'd16;

  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic special;
    logic mul_done;
    logic norm_done;
    logic div_done;
    logic zero;
    logic c_zero;
  } dp_status_t;

endpackage

// ===== rtl/lcru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcru_ctrl
// Configuration registers, matrix position counters, handshakes and the
// sequencer that steps the datapath through each element.
// ----------------------------------------------------------------------------
module lcru_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          cfg_we,
  input  logic [lcru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcru_pkg::CFG_W-1:0]     cfg_data,
  output lcru_pkg::dp_cmd_t             cmd,
  input  lcru_pkg::dp_status_t          status
);

  localparam int CW = lcru_pkg::CNT_W;
  localparam int SW = 5;

  localparam logic [SW-1:0] ST_IDLE    = 5'd0;
  localparam logic [SW-1:0] ST_FSEL    = 5'd1;
  localparam logic [SW-1:0] ST_FSPEC   = 5'd2;
  localparam logic [SW-1:0] ST_MUL     = 5'd3;
  localparam logic [SW-1:0] ST_LOADP   = 5'd4;
  localparam logic [SW-1:0] ST_NORMP   = 5'd5;
  localparam logic [SW-1:0] ST_LOADC   = 5'd6;
  localparam logic [SW-1:0] ST_NORMC   = 5'd7;
  localparam logic [SW-1:0] ST_SAVEC   = 5'd8;
  localparam logic [SW-1:0] ST_ALIGN   = 5'd9;
  localparam logic [SW-1:0] ST_ADD     = 5'd10;
  localparam logic [SW-1:0] ST_NORMR   = 5'd11;
  localparam logic [SW-1:0] ST_ROUND   = 5'd12;
  localparam logic [SW-1:0] ST_RSPEC   = 5'd13;
  localparam logic [SW-1:0] ST_NORMX   = 5'd14;
  localparam logic [SW-1:0] ST_DIVINIT = 5'd15;
  localparam logic [SW-1:0] ST_DIV     = 5'd16;
  localparam logic [SW-1:0] ST_LOADQ   = 5'd17;
  localparam logic [SW-1:0] ST_DONE    = 5'd18;

  logic [SW-1:0]                  state, state_next;
  logic [lcru_pkg::CFG_W-1:0]     row_count, col_count, start_row;
  logic [lcru_pkg::ROW_W-1:0]     row_index;
  logic [lcru_pkg::COL_W-1:0]     col_index;
  logic [lcru_pkg::OP_W-1:0]      op_q;
  logic [lcru_pkg::ROW_W-1:0]     row_q;
  logic                           last_q;

  logic [CW-1:0] rows, cols, start, rc, cc, sr, r_ext, c_ext, r1, c1;
  logic [lcru_pkg::ROW_W-1:0] r_eff;
  logic [lcru_pkg::COL_W-1:0] c_eff;
  logic [lcru_pkg::OP_W-1:0]  op_sel;
  logic                       last_sel, accept, cfg_hit, out_free;

  always_comb begin
    rc = CW'(row_count);
    cc = CW'(col_count);
    sr = CW'(start_row);
    rows = (rc == '0) ? CW'(1) : ((rc > CW'(lcru_pkg::MAX_ROWS)) ? CW'(lcru_pkg::MAX_ROWS) : rc);
    cols = (cc == '0) ? CW'(1) : ((cc > CW'(lcru_pkg::MAX_COLS)) ? CW'(lcru_pkg::MAX_COLS) : cc);
    start = (sr == '0) ? CW'(1) : ((sr > rows) ? rows : sr);
    r_eff = (CW'(row_index) >= rows) ? '0 : row_index;
    c_eff = (CW'(col_index) >= cols) ? '0 : col_index;
    r_ext = CW'(r_eff);
    c_ext = CW'(c_eff);
    r1 = r_ext + CW'(1);
    c1 = c_ext + CW'(1);
    last_sel = (r_ext == rows - CW'(1)) && (c_ext == cols - CW'(1));
    if (c_eff == '0) begin
      if (r_eff == '0) op_sel = lcru_pkg::OP_RECIP;
      else if (r_ext >= start) op_sel = lcru_pkg::OP_SCALE;
      else op_sel = lcru_pkg::OP_PASS;
    end else begin
      if (r_eff == '0) op_sel = lcru_pkg::OP_FACTOR;
      else if (r_ext >= start) op_sel = lcru_pkg::OP_UPDATE;
      else op_sel = lcru_pkg::OP_PASS;
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign cfg_hit  = cfg_we && (cfg_index inside {lcru_pkg::REG_ROW_COUNT,
                                                 lcru_pkg::REG_COL_COUNT,
                                                 lcru_pkg::REG_START_ROW});
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op_sel)
            lcru_pkg::OP_RECIP:  state_next = ST_RSPEC;
            lcru_pkg::OP_SCALE,
            lcru_pkg::OP_UPDATE: state_next = ST_FSEL;
            default:             state_next = ST_DONE;
          endcase
        end
      end
      ST_FSEL:    state_next = ST_FSPEC;
      ST_FSPEC:   state_next = status.special ? ST_DONE : ST_MUL;
      ST_MUL:     if (status.mul_done) state_next = ST_LOADP;
      ST_LOADP:   state_next = ST_NORMP;
      ST_NORMP: begin
        if (status.norm_done) state_next = status.c_zero ? ST_ROUND : ST_LOADC;
      end
      ST_LOADC:   state_next = ST_NORMC;
      ST_NORMC:   if (status.norm_done) state_next = ST_SAVEC;
      ST_SAVEC:   state_next = ST_ALIGN;
      ST_ALIGN:   state_next = ST_ADD;
      ST_ADD:     state_next = status.zero ? ST_DONE : ST_NORMR;
      ST_NORMR:   if (status.norm_done) state_next = ST_ROUND;
      ST_ROUND:   state_next = ST_DONE;
      ST_RSPEC:   state_next = status.special ? ST_DONE : ST_NORMX;
      ST_NORMX:   if (status.norm_done) state_next = ST_DIVINIT;
      ST_DIVINIT: state_next = ST_DIV;
      ST_DIV:     if (status.div_done) state_next = ST_LOADQ;
      ST_LOADQ:   state_next = ST_NORMR;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = op_q;
    cmd.row  = row_q;
    cmd.last = last_q;
    case (state)
      ST_IDLE: begin
        cmd.code = accept ? lcru_pkg::CMD_CAPTURE : lcru_pkg::CMD_NOP;
        cmd.op   = op_sel;
        cmd.row  = r_eff;
        cmd.last = last_sel;
      end
      ST_FSEL:    cmd.code = lcru_pkg::CMD_FSEL;
      ST_FSPEC:   cmd.code = lcru_pkg::CMD_FSPEC;
      ST_MUL:     cmd.code = lcru_pkg::CMD_MUL;
      ST_LOADP:   cmd.code = lcru_pkg::CMD_LOADP;
      ST_NORMP,
      ST_NORMC,
      ST_NORMR,
      ST_NORMX:   cmd.code = lcru_pkg::CMD_NORM;
      ST_LOADC:   cmd.code = lcru_pkg::CMD_LOADC;
      ST_SAVEC:   cmd.code = lcru_pkg::CMD_SAVEC;
      ST_ALIGN:   cmd.code = lcru_pkg::CMD_ALIGN;
      ST_ADD:     cmd.code = lcru_pkg::CMD_ADD;
      ST_ROUND:   cmd.code = lcru_pkg::CMD_ROUND;
      ST_RSPEC:   cmd.code = lcru_pkg::CMD_RSPEC;
      ST_DIVINIT: cmd.code = lcru_pkg::CMD_DIVINIT;
      ST_DIV:     cmd.code = lcru_pkg::CMD_DIV;
      ST_LOADQ:   cmd.code = lcru_pkg::CMD_LOADQ;
      ST_DONE:    cmd.code = out_free ? lcru_pkg::CMD_FINISH : lcru_pkg::CMD_NOP;
      default:    cmd.code = lcru_pkg::CMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_count <= lcru_pkg::CFG_W'(64);
      col_count <= lcru_pkg::CFG_W'(64);
      start_row <= lcru_pkg::CFG_W'(1);
      row_index <= '0;
      col_index <= '0;
      out_valid <= 1'b0;
      op_q      <= lcru_pkg::OP_PASS;
      row_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        op_q   <= op_sel;
        row_q  <= r_eff;
        last_q <= last_sel;
      end
      if (cfg_hit) begin
        row_index <= '0;
        col_index <= '0;
        case (cfg_index)
          lcru_pkg::REG_ROW_COUNT: row_count <= cfg_data;
          lcru_pkg::REG_COL_COUNT: col_count <= cfg_data;
          default:                 start_row <= cfg_data;
        endcase
      end else if (accept) begin
        if (r1 >= rows) begin
          row_index <= '0;
          col_index <= (c1 >= cols) ? '0 : c1[lcru_pkg::COL_W-1:0];
        end else begin
          row_index <= r1[lcru_pkg::ROW_W-1:0];
          col_index <= c_eff;
        end
      end
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/lcru_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcru_datapath
// Double-precision fused multiply-add and reciprocal datapath: operand
// registers, a shared 27x27 multiplier, normalizer, aligner, restoring
// divider, rounder and the scaled column memory.
// ----------------------------------------------------------------------------
module lcru_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lcru_pkg::DATA_W-1:0] element,
  input  lcru_pkg::dp_cmd_t           cmd,
  output lcru_pkg::dp_status_t        status,
  output logic [lcru_pkg::DATA_W-1:0] updated,
  output logic                        matrix_done
);

  localparam int EW = 14;
  localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
  localparam logic [63:0] DEFAULT_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] NEG_ZERO    = 64'h8000_0000_0000_0000;

  function automatic logic is_nan(input logic [63:0] v);
    return (v[62:52] == 11'h7FF) && (v[51:0] != '0);
  endfunction

  function automatic logic is_inf(input logic [63:0] v);
    return (v[62:0] == INF_BITS[62:0]);
  endfunction

  function automatic logic is_zero(input logic [63:0] v);
    return (v[62:0] == '0);
  endfunction

  function automatic logic [52:0] mant(input logic [63:0] v);
    return {(v[62:52] != '0), v[51:0]};
  endfunction

  function automatic logic signed [EW-1:0] expo(input logic [63:0] v);
    return (v[62:52] == '0) ? EW'(1) : $signed({3'b000, v[62:52]});
  endfunction

  // Right shift with the shifted-out bits folded into bit 0.
  function automatic logic [127:0] shr_jam(input logic [127:0] v, input logic [7:0] n);
    logic [127:0] mask;
    mask = ~({128{1'b1}} << n);
    return (v >> n) | {127'b0, |(v & mask)};
  endfunction

  function automatic logic [7:0] shamt(input logic signed [EW-1:0] d);
    return (d > EW'(128)) ? 8'd128 : d[7:0];
  endfunction

  logic [63:0] mem [lcru_pkg::MAX_ROWS];
  logic [63:0] mem_q, x, recip, factor, opa, opb, opc, res;
  logic [105:0] acc;
  logic [1:0]   mcnt;
  logic [127:0] nr, pr, cr;
  logic signed [EW-1:0] ne, pe, ce, de;
  logic         rsign;
  logic [52:0]  dm;
  logic [53:0]  rem;
  logic [60:0]  quo;
  logic [5:0]   dcnt;

  logic sp, sc, f_spec, r_spec;
  logic [63:0] f_val, r_val, round_val;
  logic [52:0] ma, mb;
  logic [26:0] ah, bh;
  logic [53:0] pp;
  logic [105:0] pp_sh;
  logic signed [EW-1:0] ep, diff;

  assign sp = opa[63] ^ opb[63] ^ (cmd.op == lcru_pkg::OP_UPDATE);
  assign sc = opc[63];
  assign ma = mant(opa);
  assign mb = mant(opb);
  assign ep = expo(opa) + expo(opb) - EW'(2150);
  assign diff = pe - ce;

  always_comb begin
    f_spec = 1'b1;
    f_val  = DEFAULT_NAN;
    if (is_nan(opa)) f_val = opa | QUIET_BIT;
    else if (is_nan(opb)) f_val = opb | QUIET_BIT;
    else if (is_nan(opc)) f_val = opc | QUIET_BIT;
    else if (is_inf(opa) || is_inf(opb)) begin
      if (is_zero(opa) || is_zero(opb)) f_val = DEFAULT_NAN;
      else if (is_inf(opc) && (sc != sp)) f_val = DEFAULT_NAN;
      else f_val = {sp, INF_BITS[62:0]};
    end else if (is_inf(opc)) f_val = opc;
    else if (is_zero(opa) || is_zero(opb)) begin
      f_val = is_zero(opc) ? {sp & sc, 63'b0} : opc;
    end else f_spec = 1'b0;
  end

  always_comb begin
    r_spec = 1'b1;
    r_val  = {x[63], INF_BITS[62:0]};
    if (is_zero(x)) r_val = {x[63], INF_BITS[62:0]};
    else if (is_nan(x)) r_val = x | QUIET_BIT;
    else if (is_inf(x)) r_val = {x[63], 63'b0};
    else r_spec = 1'b0;
  end

  // One partial product of the 53x53 significand product per cycle.
  always_comb begin
    ah = mcnt[1] ? ma[52:26] : {1'b0, ma[25:0]};
    bh = mcnt[0] ? mb[52:26] : {1'b0, mb[25:0]};
    pp = ah * bh;
    case (mcnt)
      2'd0:    pp_sh = {52'b0, pp};
      2'd3:    pp_sh = {pp, 52'b0};
      default: pp_sh = {26'b0, pp, 26'b0};
    endcase
  end

  // Rounding of nr * 2^ne with nr[127] set, nearest-even, gradual underflow.
  always_comb begin
    logic signed [EW-1:0] be, be_eff, be2, dsh;
    logic [127:0] j;
    logic [52:0]  q53, qf;
    logic [53:0]  q54;
    logic [10:0]  bfield;
    be     = ne + EW'(1150);
    be_eff = (be < EW'(1)) ? EW'(1) : be;
    dsh    = (be_eff - be) + EW'(73);
    j      = shr_jam(nr, shamt(dsh));
    q53    = j[54:2];
    q54    = {1'b0, q53} + {53'b0, j[1] & (j[0] | q53[0])};
    if (q54[53]) begin
      qf  = q54[53:1];
      be2 = be_eff + EW'(1);
    end else begin
      qf  = q54[52:0];
      be2 = be_eff;
    end
    bfield = 11'(be2 - EW'(1));
    if (be >= EW'(2047) || be2 >= EW'(2047)) round_val = {rsign, INF_BITS[62:0]};
    else round_val = {rsign, {bfield, 52'b0} + {10'b0, qf}};
  end

  assign status.special   = (cmd.code == lcru_pkg::CMD_RSPEC) ? r_spec : f_spec;
  assign status.mul_done  = (mcnt == 2'd3);
  assign status.norm_done = nr[127];
  assign status.div_done  = (dcnt == 6'd60);
  assign status.zero      = (sp != sc) && (pr == cr);
  assign status.c_zero    = is_zero(opc);

  always_ff @(posedge clk) begin
    mem_q <= mem[cmd.row];
    if (cmd.code == lcru_pkg::CMD_FINISH && cmd.op == lcru_pkg::OP_SCALE) mem[cmd.row] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recip  <= '0;
      factor <= '0;
    end else if (cmd.code == lcru_pkg::CMD_FINISH) begin
      if (cmd.op == lcru_pkg::OP_RECIP) recip <= res;
      if (cmd.op == lcru_pkg::OP_FACTOR) factor <= x;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.code)
      lcru_pkg::CMD_CAPTURE: x <= element;
      lcru_pkg::CMD_FSEL: begin
        if (cmd.op == lcru_pkg::OP_SCALE) begin
          opa <= x;
          opb <= recip;
          opc <= NEG_ZERO;
        end else begin
          opa <= factor;
          opb <= mem_q;
          opc <= x;
        end
      end
      lcru_pkg::CMD_FSPEC: begin
        res  <= f_val;
        acc  <= '0;
        mcnt <= 2'd0;
      end
      lcru_pkg::CMD_MUL: begin
        acc  <= acc + pp_sh;
        mcnt <= mcnt + 2'd1;
      end
      lcru_pkg::CMD_LOADP: begin
        nr    <= {22'b0, acc};
        ne    <= ep;
        rsign <= sp;
      end
      lcru_pkg::CMD_NORM: begin
        if (nr[127:64] == '0) begin
          nr <= nr << 64;
          ne <= ne - EW'(64);
        end else if (nr[127:112] == '0) begin
          nr <= nr << 16;
          ne <= ne - EW'(16);
        end else if (!nr[127]) begin
          nr <= nr << 1;
          ne <= ne - EW'(1);
        end
      end
      lcru_pkg::CMD_LOADC: begin
        pr <= nr >> 2;
        pe <= ne + EW'(2);
        nr <= {75'b0, mant(opc)};
        ne <= expo(opc) - EW'(1075);
      end
      lcru_pkg::CMD_SAVEC: begin
        cr <= nr >> 2;
        ce <= ne + EW'(2);
      end
      lcru_pkg::CMD_ALIGN: begin
        if (!diff[EW-1]) begin
          cr <= shr_jam(cr, shamt(diff));
          ne <= pe;
        end else begin
          pr <= shr_jam(pr, shamt(-diff));
          ne <= ce;
        end
      end
      lcru_pkg::CMD_ADD: begin
        if (sp == sc) begin
          nr    <= pr + cr;
          rsign <= sp;
        end else if (pr == cr) begin
          // Exact cancellation gives positive zero.
          res <= '0;
        end else if (pr > cr) begin
          nr    <= pr - cr;
          rsign <= sp;
        end else begin
          nr    <= cr - pr;
          rsign <= sc;
        end
      end
      lcru_pkg::CMD_ROUND: res <= round_val;
      lcru_pkg::CMD_RSPEC: begin
        res   <= r_val;
        nr    <= {75'b0, mant(x)};
        ne    <= expo(x) - EW'(1075);
        rsign <= x[63];
      end
      lcru_pkg::CMD_DIVINIT: begin
        dm   <= nr[127:75];
        de   <= -EW'(188) - ne;
        rem  <= 54'd1 << 52;
        quo  <= '0;
        dcnt <= '0;
      end
      lcru_pkg::CMD_DIV: begin
        if (rem >= {1'b0, dm}) begin
          rem <= (rem - {1'b0, dm}) << 1;
          quo <= {quo[59:0], 1'b1};
        end else begin
          rem <= rem << 1;
          quo <= {quo[59:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
      end
      lcru_pkg::CMD_LOADQ: begin
        nr <= {66'b0, quo, |rem};
        ne <= de;
      end
      lcru_pkg::CMD_FINISH: begin
        if (cmd.op == lcru_pkg::OP_SCALE || cmd.op == lcru_pkg::OP_UPDATE) updated <= res;
        else updated <= x;
        matrix_done <= cmd.last;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/lu_column_scale_rank1_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_column_scale_rank1_update_unit
// One LU elimination step on a column-major double matrix streamed one
// element per transaction: pivot reciprocal, column scaling, rank-one update.
// ----------------------------------------------------------------------------
//  Channel  Signals                          Direction
//  input    in_valid, in_stall, element      element in, stall out
//  output   out_valid, out_stall, updated,   result out, stall in
//           matrix_done
//  config   cfg_we, cfg_index, cfg_data      write only
//
// Pass-through elements skip the arithmetic; a NaN, infinite or zero operand
// ends a scale or update at the special-value check. Scaled and updated
// elements are paced by the shared 27x27 multiplier (4 passes) and the
// normalizer; subnormal operands and near cancellation add normalizer
// steps. The pivot is paced by the 61-step divider.
// One element is in work at a time; a finished transaction waits in the
// output register while the next element is accepted. Reset is synchronous
// and needs no clearing pass; the scaled column memory is written before read.
// ----------------------------------------------------------------------------
module lu_column_scale_rank1_update_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lcru_pkg::DATA_W-1:0]    element,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lcru_pkg::DATA_W-1:0]    updated,
  output logic                           matrix_done,
  input  logic                           cfg_we,
  input  logic [lcru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcru_pkg::CFG_W-1:0]     cfg_data
);

  lcru_pkg::dp_cmd_t    cmd;
  lcru_pkg::dp_status_t status;

  lcru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  lcru_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .element     (element),
    .cmd         (cmd),
    .status      (status),
    .updated     (updated),
    .matrix_done (matrix_done)
  );

endmodule

// ===== tb/tb_lu_column_scale_rank1_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lu_column_scale_rank1_update_unit
// Streams column-major double matrices through the LU column scale and
// rank-one update unit and checks every transaction against a bit-exact
// software predictor (pivot reciprocal, scaling, fused update).
// ----------------------------------------------------------------------------
module tb_lu_column_scale_rank1_update_unit;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [63:0] NEG_ZERO   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF    = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_DFLT  = 64'h7FF8_0000_0000_0000;
  // An index past the register list; writes to it are ignored.
  localparam logic [lcru_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [63:0] value;
    logic        done;
  } lu_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [lcru_pkg::DATA_W-1:0]    element = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [lcru_pkg::DATA_W-1:0]    updated;
  logic                           matrix_done;
  logic                           cfg_we = 1'b0;
  logic [lcru_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lcru_pkg::CFG_W-1:0]     cfg_data = '0;

  lu_column_scale_rank1_update_unit dut (.*);

  always #4 clk = ~clk;

  // Predictor state.
  logic [6:0]  row_count_reg, col_count_reg, start_row_reg;
  logic [63:0] recip_held, factor_held;
  logic [63:0] scaled_mem [lcru_pkg::MAX_ROWS];
  int unsigned cur_row, cur_col;
  lu_result_t  pending_results[$];
  int          error_count = 0;
  bit          calm = 1'b0;
  int          out_wait = 0;
  int          idle_cycles = 0;

  function automatic int top_bit(logic [127:0] v);
    for (int i = 127; i >= 0; i--) if (v[i]) return i;
    return -1;
  endfunction

  function automatic logic [127:0] shr_jam(logic [127:0] v, longint n);
    logic [127:0] r;
    if (n == 0) return v;
    if (n >= 128) return {127'b0, |v};
    r = v >> n;
    r[0] = r[0] | (|(v & ((128'b1 << n) - 128'b1)));
    return r;
  endfunction

  function automatic logic [63:0] round_pack(logic sign, logic [127:0] r, longint e);
    int          t;
    longint      be, be_eff, sh;
    logic [63:0] q;
    logic [127:0] j;
    logic        rb, st;
    t = top_bit(r);
    be = t + e + 1023;
    be_eff = (be < 1) ? 1 : be;
    sh = t - 52 + (be_eff - be);
    rb = 1'b0;
    st = 1'b0;
    if (be >= 2047) return {sign, POS_INF[62:0]};
    if (sh <= 0) begin
      q = r[63:0] << (-sh);
    end else begin
      j = (sh == 1) ? (r << 1) : shr_jam(r, sh - 2);
      q = j[63:0] >> 2;
      rb = j[1];
      st = j[0];
    end
    if (rb && (st || q[0])) q++;
    if (q == 64'h0020_0000_0000_0000) begin
      q = q >> 1;
      be_eff++;
    end
    if (be_eff >= 2047) return {sign, POS_INF[62:0]};
    return {sign, 63'b0} | ((64'(be_eff - 1) << 52) + q);
  endfunction

  function automatic bit is_nan(logic [63:0] x);
    return x[62:52] == 11'h7FF && x[51:0] != 0;
  endfunction
  function automatic bit is_inf(logic [63:0] x);
    return x[62:0] == POS_INF[62:0];
  endfunction
  function automatic bit is_zero(logic [63:0] x);
    return x[62:0] == 0;
  endfunction

  // (neg ? -(a*b) : a*b) + c, rounded once to nearest even.
  function automatic logic [63:0] fused_mac(logic [63:0] a, logic [63:0] b,
                                            logic [63:0] c, bit neg);
    logic         sp, sc, sign;
    longint       ea, eb, ec, ep, ecx, e;
    logic [127:0] p, cw, r;
    int           tp, tc;
    sp = a[63] ^ b[63] ^ neg;
    sc = c[63];
    if (is_nan(a)) return a | 64'h0008_0000_0000_0000;
    if (is_nan(b)) return b | 64'h0008_0000_0000_0000;
    if (is_nan(c)) return c | 64'h0008_0000_0000_0000;
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return QNAN_DFLT;
      if (is_inf(c) && sc != sp) return QNAN_DFLT;
      return {sp, POS_INF[62:0]};
    end
    if (is_inf(c)) return c;
    if (is_zero(a) || is_zero(b)) begin
      if (is_zero(c)) return {sp & sc, 63'b0};
      return c;
    end
    ea = a[62:52];
    eb = b[62:52];
    ec = c[62:52];
    p = {75'b0, ea != 0, a[51:0]} * {75'b0, eb != 0, b[51:0]};
    ep = (ea != 0 ? ea : 1) + (eb != 0 ? eb : 1) - 2150;
    tp = top_bit(p);
    p = p << (125 - tp);
    ep -= 125 - tp;
    if (is_zero(c)) begin
      r = p;
      e = ep;
      sign = sp;
    end else begin
      cw = {75'b0, ec != 0, c[51:0]};
      tc = top_bit(cw);
      cw = cw << (125 - tc);
      ecx = (ec != 0 ? ec : 1) - 1075 - (125 - tc);
      if (ep >= ecx) begin
        cw = shr_jam(cw, ep - ecx);
        e = ep;
      end else begin
        p = shr_jam(p, ecx - ep);
        e = ecx;
      end
      if (sp == sc) begin
        r = p + cw;
        sign = sp;
      end else if (p == cw) begin
        return 64'b0;
      end else if (p > cw) begin
        r = p - cw;
        sign = sp;
      end else begin
        r = cw - p;
        sign = sc;
      end
    end
    return round_pack(sign, r, e);
  endfunction

  function automatic logic [63:0] pivot_reciprocal(logic [63:0] x);
    if (is_zero(x)) return {x[63], POS_INF[62:0]};
    if (is_nan(x)) return x | 64'h0008_0000_0000_0000;
    return $realtobits(1.0 / $bitstoreal(x));
  endfunction

  function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
    return (v < 1) ? 1 : ((v > hi) ? hi : v);
  endfunction

  // Advances the predictor by one element and queues the expected result.
  task automatic eliminate_element(logic [63:0] x);
    int unsigned rows, cols, start;
    lu_result_t  res;
    rows = clamp_count(row_count_reg, lcru_pkg::MAX_ROWS);
    cols = clamp_count(col_count_reg, lcru_pkg::MAX_COLS);
    start = clamp_count(start_row_reg, rows);
    if (cur_row >= rows) cur_row = 0;
    if (cur_col >= cols) cur_col = 0;
    res.value = x;
    if (cur_col == 0) begin
      if (cur_row == 0) begin
        recip_held = pivot_reciprocal(x);
      end else if (cur_row >= start) begin
        res.value = fused_mac(x, recip_held, NEG_ZERO, 1'b0);
        scaled_mem[cur_row] = res.value;
      end
    end else begin
      if (cur_row == 0) factor_held = x;
      else if (cur_row >= start)
        res.value = fused_mac(factor_held, scaled_mem[cur_row], x, 1'b1);
    end
    res.done = (cur_row == rows - 1) && (cur_col == cols - 1);
    pending_results.push_back(res);
    cur_row++;
    if (cur_row >= rows) begin
      cur_row = 0;
      cur_col++;
      if (cur_col >= cols) cur_col = 0;
    end
  endtask

  function automatic int draw_wait();
    if (calm || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_element(logic [63:0] x);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element <= x;
    do @(posedge clk); while (in_stall);
    eliminate_element(x);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [lcru_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcru_pkg::REG_ROW_COUNT: row_count_reg = val;
      lcru_pkg::REG_COL_COUNT: col_count_reg = val;
      lcru_pkg::REG_START_ROW: start_row_reg = val;
      default: ;
    endcase
    // Writes outside the register list are ignored and do not restart.
    if (idx inside {lcru_pkg::REG_ROW_COUNT, lcru_pkg::REG_COL_COUNT,
                    lcru_pkg::REG_START_ROW}) begin
      cur_row = 0;
      cur_col = 0;
    end
  endtask

  task automatic set_shape(logic [6:0] rows, logic [6:0] cols, logic [6:0] start);
    write_reg(lcru_pkg::REG_ROW_COUNT, rows);
    write_reg(lcru_pkg::REG_COL_COUNT, cols);
    write_reg(lcru_pkg::REG_START_ROW, start);
  endtask

  function automatic logic [63:0] random_double();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: begin
        case ($urandom_range(0, 7))
          0: return {$urandom_range(0, 1) == 1, 63'b0};
          1: return {$urandom_range(0, 1) == 1, POS_INF[62:0]};
          2: return {$urandom_range(0, 1) == 1, 11'h7FF, 1'b1, 19'($urandom), $urandom};
          3: return {$urandom_range(0, 1) == 1, 11'h7FF, 1'b0, 18'($urandom), 1'b1, $urandom};
          4: return {$urandom_range(0, 1) == 1, 11'h000, 20'($urandom), $urandom};
          5: return {$urandom_range(0, 1) == 1, 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
          6: return {$urandom_range(0, 1) == 1, 11'($urandom_range(1, 60)), 20'($urandom),
                     $urandom};
          default: return {$urandom_range(0, 1) == 1, 11'($urandom_range(1990, 2046)),
                           20'($urandom), $urandom};
        endcase
      end
      default: return {$urandom_range(0, 1) == 1, 11'($urandom_range(1013, 1033)),
                       20'($urandom), $urandom};
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_element(random_double());
  endtask

  // Reset values: 64 rows, 64 columns, updates from row 1.
  task automatic test_reset_shape();
    calm = 1'b0;
    send_random(72);
  endtask

  task automatic test_special_values();
    logic [63:0] vals [12];
    vals = '{64'h4000_0000_0000_0000, POS_INF, 64'h7FF0_0000_0000_0001,
             64'h0000_0000_0000_0001, QNAN_DFLT | NEG_ZERO, 64'hFFEF_FFFF_FFFF_FFFF,
             NEG_ZERO, 64'h3FF0_0000_0000_0000, POS_INF | NEG_ZERO,
             64'h0000_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF, 64'h7FF4_0000_0000_0000};
    set_shape(7'd4, 7'd3, 7'd1);
    foreach (vals[i]) send_element(vals[i]);
    // Zero, negative zero and NaN pivots, and an infinite factor.
    set_shape(7'd2, 7'd2, 7'd1);
    send_element(64'h0); send_element(64'h3FF0_0000_0000_0000);
    send_element(64'h0); send_element(64'h4000_0000_0000_0000);
    send_element(NEG_ZERO); send_element(64'h0);
    send_element(POS_INF); send_element(64'h0);
    send_element(64'h7FF0_0000_0000_0002); send_element(64'h3FF0_0000_0000_0000);
  endtask

  task automatic test_count_extremes();
    set_shape(7'd0, 7'd0, 7'd0);
    send_random(4);
    set_shape(7'd127, 7'd1, 7'd127);
    send_random(66);
    set_shape(7'd64, 7'd2, 7'd64);
    send_random(128);
    set_shape(7'd5, 7'd3, 7'd3);
    send_random(15);
    set_shape(7'd3, 7'd127, 7'd2);
    send_random(6);
  endtask

  task automatic test_ignored_index();
    set_shape(7'd3, 7'd3, 7'd1);
    send_random(4);
    write_reg(REG_UNUSED, 7'($urandom));
    send_random(5);
  endtask

  task automatic test_random_matrices();
    int sent, rows, cols, cnt;
    logic [6:0] r7, c7, s7;
    sent = 0;
    while (sent < 1300) begin
      calm = ($urandom_range(0, 4) == 0);
      r7 = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(1, 64))
                                       : 7'($urandom_range(1, 6));
      c7 = (r7 > 8) ? 7'($urandom_range(1, 3)) : 7'($urandom_range(1, 8));
      s7 = 7'($urandom_range(1, r7));
      if ($urandom_range(0, 9) == 0)
        r7 = ($urandom_range(0, 1) == 1) ? 7'd0 : 7'($urandom_range(65, 127));
      if ($urandom_range(0, 9) == 0) s7 = 7'($urandom_range(0, 127));
      set_shape(r7, c7, s7);
      rows = clamp_count(r7, lcru_pkg::MAX_ROWS);
      cols = clamp_count(c7, lcru_pkg::MAX_COLS);
      cnt = rows * cols * $urandom_range(1, 3);
      if ($urandom_range(0, 7) == 0) cnt = $urandom_range(1, rows * cols);
      send_random(cnt);
      sent += cnt;
    end
    calm = 1'b0;
  endtask

  // Result side: random stalls and in-order comparison.
  always @(posedge clk) begin
    lu_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected transaction: updated %h", updated);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (updated !== want.value) begin
            $error("updated: expected %h, actual %h", want.value, updated);
            error_count++;
          end
          if (matrix_done !== want.done) begin
            $error("matrix_done: expected %b, actual %b", want.done, matrix_done);
            error_count++;
          end
        end
        out_wait = draw_wait();
      end else if (out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    row_count_reg = 7'd64;
    col_count_reg = 7'd64;
    start_row_reg = 7'd1;
    recip_held = '0;
    factor_held = '0;
    cur_row = 0;
    cur_col = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_shape();
    test_special_values();
    test_count_extremes();
    test_ignored_index();
    test_random_matrices();
    drain_results();
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
